// ===== rtl/ipg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipg_pkg
// Shared widths, command codes and the read-pipeline record of the integer
// partition generator.
// ----------------------------------------------------------------------------
package ipg_pkg;

	// largest total and store depth
	localparam int MAX_TOTAL = 32;
	localparam int IDX_W     = $clog2(MAX_TOTAL);
	localparam int CNT_W     = $clog2(MAX_TOTAL + 1);

	// payload field widths
	localparam int CMD_W   = 1;
	localparam int TOTAL_W = 6;
	localparam int PART_W  = 6;
	localparam int POS_W   = 5;

	// request command codes
	localparam logic [CMD_W-1:0] CMD_START = 1'b0;
	localparam logic [CMD_W-1:0] CMD_NEXT  = 1'b1;

	// one pending result between the store read and the output register
	typedef struct packed {
		logic             valid;
		logic             exh;
		logic [POS_W-1:0] pos;
		logic             last;
		logic             fin;
	} ipg_pend_t;

endpackage

// ===== rtl/ipg_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipg_req_if
// Request channel: a start or next command with the total to partition.
// ----------------------------------------------------------------------------
interface ipg_req_if;

	logic                          valid;
	logic                          ready;
	logic [ipg_pkg::CMD_W-1:0]     command;
	logic [ipg_pkg::TOTAL_W-1:0]   total;

	modport source (output valid, output command, output total, input ready);
	modport sink   (input valid, input command, input total, output ready);

endinterface

// ===== rtl/ipg_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipg_rsp_if
// Result channel: one part of a partition with its position and marks.
// ----------------------------------------------------------------------------
interface ipg_rsp_if;

	logic                        valid;
	logic                        ready;
	logic [ipg_pkg::PART_W-1:0]  part;
	logic [ipg_pkg::POS_W-1:0]   position;
	logic                        last_part;
	logic                        final_partition;
	logic                        exhausted;

	modport source (output valid, output part, output position, output last_part,
		output final_partition, output exhausted, input ready);
	modport sink   (input valid, input part, input position, input last_part,
		input final_partition, input exhausted, output ready);

endinterface

// ===== rtl/ipg_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipg_out_stage
// Output register of the result channel. Takes a pending result together
// with the store read data and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module ipg_out_stage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ipg_pkg::ipg_pend_t         pend,
	input  logic [ipg_pkg::PART_W-1:0] rd_data,
	output logic                       take,
	ipg_rsp_if.source                  rsp
);

	logic                       valid_q;
	logic [ipg_pkg::PART_W-1:0] part_q;
	logic [ipg_pkg::POS_W-1:0]  position_q;
	logic                       last_q;
	logic                       fin_q;
	logic                       exh_q;

	// load when the register is empty or being emptied
	assign take = pend.valid && (!valid_q || rsp.ready);

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload, exhausted results carry a zero part
	always_ff @(posedge clk) begin
		if (take) begin
			part_q     <= pend.exh ? '0 : rd_data;
			position_q <= pend.pos;
			last_q     <= pend.last;
			fin_q      <= pend.fin;
			exh_q      <= pend.exh;
		end
	end

	assign rsp.valid           = valid_q;
	assign rsp.part            = part_q;
	assign rsp.position        = position_q;
	assign rsp.last_part       = last_q;
	assign rsp.final_partition = fin_q;
	assign rsp.exhausted       = exh_q;

endmodule

// ===== rtl/integer_partition_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_partition_generator
// Lists the partitions of a total in reverse lexicographic order, one
// partition per request, emitted one part per result, largest part first.
//
//   channel  dir  payload
//   req      in   command, total
//   rsp      out  part, position, last_part, final_partition, exhausted
//
// A start writes the total as a single part and emits it. A next runs a
// backward scan of the store over the trailing ones, a refill (one write per
// rewritten part) and then emits the parts, one store read per part.
// There is no clearing pass after reset: store entries are read only once
// written. A stalled sink holds the output register; the next request is
// taken once the last part has left the read stage.
// ----------------------------------------------------------------------------
module integer_partition_generator (
	input  logic      clk,
	input  logic      arst_n,
	ipg_req_if.sink   req,
	ipg_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [ipg_pkg::CNT_W-1:0]  count_q;
	logic [ipg_pkg::PART_W-1:0] target_q;
	logic                       active_q;
	logic [ipg_pkg::IDX_W-1:0]  j_q;
	logic [ipg_pkg::IDX_W-1:0]  k_q;
	logic [ipg_pkg::PART_W-1:0] v_q;
	logic [ipg_pkg::PART_W-1:0] rem_q;
	logic [ipg_pkg::CNT_W-1:0]  e_q;
	ipg_pkg::ipg_pend_t         pend_q;

	// part store
	logic [ipg_pkg::PART_W-1:0] mem [ipg_pkg::MAX_TOTAL];
	logic [ipg_pkg::PART_W-1:0] rd_data_q;
	logic                       rd_en;
	logic [ipg_pkg::IDX_W-1:0]  rd_addr;
	logic                       wr_en;
	logic [ipg_pkg::IDX_W-1:0]  wr_addr;
	logic [ipg_pkg::PART_W-1:0] wr_data;

	logic                       req_fire;
	logic                       is_start;
	logic [ipg_pkg::PART_W-1:0] tot_sat;
	logic                       next_dead;
	logic                       scan_more;
	logic [ipg_pkg::PART_W-1:0] fill_wv;
	logic [ipg_pkg::PART_W-1:0] fill_rem;
	logic                       emit_last;
	logic                       issue;
	logic                       take;

	// request decode
	assign req.ready = (state_q == ST_IDLE) && !pend_q.valid;
	assign req_fire  = req.valid && req.ready;
	assign is_start  = (req.command == ipg_pkg::CMD_START);
	assign tot_sat   = (req.total > ipg_pkg::PART_W'(ipg_pkg::MAX_TOTAL)) ?
		ipg_pkg::PART_W'(ipg_pkg::MAX_TOTAL) : req.total;
	assign next_dead = !active_q || (count_q == '0) ||
		(ipg_pkg::PART_W'(count_q) >= target_q);

	// scan, refill and emit steps
	assign scan_more = (j_q != '0) && (rd_data_q <= ipg_pkg::PART_W'(1));
	assign fill_wv   = (rem_q >= v_q) ? v_q : rem_q;
	assign fill_rem  = rem_q - fill_wv;
	assign emit_last = ((e_q + ipg_pkg::CNT_W'(1)) == count_q);
	assign issue     = (state_q == ST_EMIT) && (!pend_q.valid || take);

	// store port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && is_start && (req.total != '0)) begin
					wr_en   = 1'b1;
					wr_data = tot_sat;
				end
				if (req_fire && !is_start && !next_dead) begin
					rd_en   = 1'b1;
					rd_addr = ipg_pkg::IDX_W'(count_q - ipg_pkg::CNT_W'(1));
				end
			end
			ST_SCAN: begin
				if (scan_more) begin
					rd_en   = 1'b1;
					rd_addr = j_q - ipg_pkg::IDX_W'(1);
				end
			end
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
				wr_data = fill_wv;
			end
			ST_EMIT: begin
				rd_en   = issue;
				rd_addr = e_q[ipg_pkg::IDX_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// synchronous store, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			target_q <= '0;
			active_q <= 1'b0;
			j_q      <= '0;
			k_q      <= '0;
			v_q      <= '0;
			rem_q    <= '0;
			e_q      <= '0;
			pend_q   <= '0;
		end else begin
			// free the pending slot unless a new part is issued on the same edge
			if (take && !issue) begin
				pend_q.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if ((is_start && (req.total == '0)) || (!is_start && next_dead)) begin
							// exhausted result
							active_q <= 1'b0;
							pend_q   <= '{valid: 1'b1, exh: 1'b1, pos: '0, last: 1'b1,
								fin: 1'b0};
						end else if (is_start) begin
							target_q <= tot_sat;
							count_q  <= ipg_pkg::CNT_W'(1);
							active_q <= 1'b1;
							e_q      <= '0;
							state_q  <= ST_EMIT;
						end else begin
							j_q     <= ipg_pkg::IDX_W'(count_q - ipg_pkg::CNT_W'(1));
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// walk back over trailing ones to the part to lower
					if (scan_more) begin
						j_q <= j_q - ipg_pkg::IDX_W'(1);
					end else begin
						v_q     <= rd_data_q - ipg_pkg::PART_W'(1);
						rem_q   <= rd_data_q + ipg_pkg::PART_W'(count_q -
							ipg_pkg::CNT_W'(1) - ipg_pkg::CNT_W'(j_q));
						k_q     <= j_q;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					// refill with the lowered part, then the remainder
					rem_q <= fill_rem;
					k_q   <= k_q + ipg_pkg::IDX_W'(1);
					if (fill_rem == '0) begin
						count_q <= ipg_pkg::CNT_W'(k_q) + ipg_pkg::CNT_W'(1);
						e_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// one store read per part
					if (issue) begin
						pend_q <= '{valid: 1'b1, exh: 1'b0,
							pos: ipg_pkg::POS_W'(e_q), last: emit_last,
							fin: (ipg_pkg::PART_W'(count_q) == target_q)};
						e_q    <= e_q + ipg_pkg::CNT_W'(1);
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ipg_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.pend    (pend_q),
		.rd_data (rd_data_q),
		.take    (take),
		.rsp     (rsp)
	);

`ifndef SYNTHESIS
	a_fill_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (rem_q != '0))
		else $error("refill entered with nothing left to place");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((count_q != '0) &&
		(ipg_pkg::PART_W'(count_q) <= target_q)))
		else $error("part count out of range while emitting");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> ((state_q == ST_SCAN) || (state_q == ST_FILL)))
		else $error("scan left without refill");

	a_exh_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q.valid && pend_q.exh) |-> (pend_q.last && (pend_q.pos == '0)))
		else $error("exhausted result not a single last part");
`endif

endmodule
